/* hdl/sts_pkg.sv */
// Package for the subtitle tag stripper: transaction payload types,
// character codes, decoder result type and default constants.
// No dependencies.
package sts_pkg;

  localparam int unsigned TagDepthDef = 64;
  localparam logic [15:0] OutLimitRst = 16'd499;

  localparam logic [7:0] ChOpen    = 8'h7B;
  localparam logic [7:0] ChClose   = 8'h7D;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChP       = 8'h70;
  localparam logic [7:0] ChUpN     = 8'h4E;
  localparam logic [7:0] ChLoN     = 8'h6E;
  localparam logic [7:0] ChH       = 8'h68;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNone    = 8'h00;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
  } out_t;

  typedef struct packed {
    logic inside_tag;
    logic drawing_mode;
    logic pending_backslash;
    logic scanning_digits;
  } flags_t;

  typedef struct packed {
    flags_t     flags;
    logic       has_first;
    logic [7:0] first_char;
    logic       has_second;
    logic [7:0] second_char;
    logic       open_tag;
  } dec_t;

endpackage

/* hdl/sts_tag_ram.sv */
// Tag byte buffer: one write port and one read port, registered read data.
// Depends on nothing but its parameters.
module sts_tag_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sts_decode.sv */
// Per-byte decoder: next tag, drawing and escape flags and the up to two
// characters one byte asks to emit. Depends on sts_pkg.
module sts_decode (
  input  sts_pkg::flags_t flags_i,
  input  sts_pkg::in_t    in_i,
  output sts_pkg::dec_t   dec_o
);
  import sts_pkg::*;

  always_comb begin
    flags_t     nf;
    logic       done;
    logic       w0;
    logic       w1;
    logic       w2;
    logic [7:0] ch0;
    logic [7:0] c;
    c    = in_i.in_char;
    nf   = flags_i;
    done = 1'b0;
    w0   = 1'b0;
    w1   = 1'b0;
    ch0  = ChBslash;
    dec_o.open_tag = 1'b0;
    if (flags_i.inside_tag) begin
      if (flags_i.scanning_digits) begin
        if (c inside {[ChZero:ChNine]}) begin
          if (c != ChZero) begin
            nf.drawing_mode = 1'b1;
          end
          done = 1'b1;
        end else begin
          nf.scanning_digits = 1'b0;
        end
      end
      if (!done && nf.pending_backslash) begin
        nf.pending_backslash = 1'b0;
        if (c == ChP) begin
          nf.drawing_mode    = 1'b0;
          nf.scanning_digits = 1'b1;
          done               = 1'b1;
        end
      end
      if (!done) begin
        if (c == ChClose) begin
          nf.inside_tag = 1'b0;
        end else if (c == ChBslash) begin
          nf.pending_backslash = 1'b1;
        end
      end
    end else begin
      if (flags_i.pending_backslash) begin
        nf.pending_backslash = 1'b0;
        if (c == ChUpN || c == ChLoN) begin
          w0   = 1'b1;
          ch0  = ChNewline;
          done = 1'b1;
        end else if (c == ChH) begin
          w0   = 1'b1;
          ch0  = ChSpace;
          done = 1'b1;
        end else if (!flags_i.drawing_mode) begin
          w0 = 1'b1;
        end
      end
      if (!done) begin
        if (c == ChBslash) begin
          nf.pending_backslash = 1'b1;
        end else if (c == ChOpen) begin
          nf.inside_tag  = 1'b1;
          dec_o.open_tag = 1'b1;
        end else if (!flags_i.drawing_mode) begin
          w1 = 1'b1;
        end
      end
    end
    w2 = in_i.end_of_text && nf.pending_backslash && !nf.inside_tag && !nf.drawing_mode;
    dec_o.flags       = nf;
    dec_o.has_first   = w0 || w1 || w2;
    dec_o.first_char  = w0 ? ch0 : (w1 ? c : ChBslash);
    dec_o.has_second  = w0 && (w1 || w2);
    dec_o.second_char = w1 ? c : ChBslash;
  end

endmodule

/* hdl/subtitle_tag_stripper.sv */
// Subtitle tag stripper top level: byte stream in, plain text out, with an
// end-of-string replay of an unclosed tag. Uses sts_pkg, sts_decode, sts_tag_ram.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_ready_o   in_data_i  (in_char, end_of_text)
//   out      out_valid_o / out_ready_i out_data_o (out_char, char_valid, last)
//   cfg      cfg_we_i                  cfg_wdata_i (out_limit)
//
// Input is held off while a second result or a tag replay is still to be sent.
// A string ending inside an open tag replays the tag through the single
// registered read port of the tag RAM, one byte per cycle while output is taken.
// Reset clears all control state at once; the tag RAM needs no clearing pass.
// Input is held off while the output register is full and not being taken.
module subtitle_tag_stripper #(
  parameter int unsigned TagDepth = sts_pkg::TagDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sts_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);
  import sts_pkg::*;

  localparam int unsigned AddrW = $clog2(TagDepth);
  localparam int unsigned LenW  = $clog2(TagDepth + 1);
  localparam logic [LenW-1:0] DepthLen = LenW'(TagDepth);
  localparam logic [LenW-1:0] OneLen   = LenW'(1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSec  = 2'd1;
  localparam logic [1:0] StRpl  = 2'd2;

  logic [1:0]      state_q, state_d;
  flags_t          flags_q, flags_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [LenW-1:0] tlen_q, tlen_d;
  logic [15:0]     lim_q, lim_d;
  out_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;
  out_t            sec_q, sec_d;
  logic [LenW-1:0] rlen_q, rlen_d;
  logic [LenW-1:0] iss_q, iss_d;
  logic [LenW-1:0] cons_q, cons_d;
  logic            dv_q, dv_d;

  dec_t            dec;
  logic            out_free;
  logic            acc;
  logic            ok0, ok1, g0, g1;
  logic [16:0]     cnt_sum;
  logic [16:0]     avail;
  logic [LenW-1:0] tlen_n;
  logic [LenW-1:0] rlen_n;
  logic            endt;
  logic            ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic            rd_en;
  logic            consume;
  logic [7:0]      rdata;
  out_t            item0, item1;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign acc        = in_valid_i && in_ready_o;
  assign endt       = in_data_i.end_of_text;

  sts_decode u_dec (
    .flags_i (flags_q),
    .in_i    (in_data_i),
    .dec_o   (dec)
  );

  assign ram_we    = acc && ((flags_q.inside_tag && (tlen_q < DepthLen)) || dec.open_tag);
  assign ram_waddr = dec.open_tag ? '0 : tlen_q[AddrW-1:0];
  assign ram_wdata = dec.open_tag ? ChOpen : in_data_i.in_char;

  assign rd_en   = (state_q == StRpl) && (iss_q < rlen_q) && (!dv_q || out_free);
  assign consume = (state_q == StRpl) && dv_q && out_free;

  sts_tag_ram #(
    .Depth (TagDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (iss_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    ok0     = cnt_q < lim_q;
    ok1     = ({1'b0, cnt_q} + 17'd1) < {1'b0, lim_q};
    g0      = dec.has_first && ok0;
    g1      = dec.has_second && ok1;
    cnt_sum = {1'b0, cnt_q} + 17'(g0) + 17'(g1);
    avail   = ({1'b0, lim_q} > cnt_sum) ? ({1'b0, lim_q} - cnt_sum) : 17'd0;
    if (flags_q.inside_tag) begin
      tlen_n = (tlen_q < DepthLen) ? (tlen_q + OneLen) : tlen_q;
    end else if (dec.open_tag) begin
      tlen_n = OneLen;
    end else begin
      tlen_n = tlen_q;
    end
    if (endt && dec.flags.inside_tag) begin
      rlen_n = (avail < 17'(tlen_n)) ? avail[LenW-1:0] : tlen_n;
    end else begin
      rlen_n = '0;
    end
    item0.out_char   = g0 ? dec.first_char : ChNone;
    item0.char_valid = g0;
    item0.last       = endt && !g1 && (rlen_n == '0);
    item1.out_char   = dec.second_char;
    item1.char_valid = 1'b1;
    item1.last       = endt && (rlen_n == '0);
  end

  always_comb begin
    state_d   = state_q;
    flags_d   = flags_q;
    cnt_d     = cnt_q;
    tlen_d    = tlen_q;
    lim_d     = cfg_we_i ? cfg_wdata_i : lim_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    sec_d     = sec_q;
    rlen_d    = rlen_q;
    iss_d     = iss_q;
    cons_d    = cons_q;
    dv_d      = dv_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (endt) begin
            flags_d = '0;
            cnt_d   = '0;
            tlen_d  = '0;
          end else begin
            flags_d = dec.flags;
            cnt_d   = cnt_sum[15:0];
            tlen_d  = tlen_n;
          end
          rlen_d = rlen_n;
          iss_d  = '0;
          cons_d = '0;
          dv_d   = 1'b0;
          if (g0 || (endt && (rlen_n == '0))) begin
            out_d     = item0;
            out_vld_d = 1'b1;
          end
          if (g1) begin
            sec_d   = item1;
            state_d = StSec;
          end else if (rlen_n != '0) begin
            state_d = StRpl;
          end
        end
      end
      StSec: begin
        if (out_free) begin
          out_d     = sec_q;
          out_vld_d = 1'b1;
          state_d   = (rlen_q != '0) ? StRpl : StIdle;
        end
      end
      StRpl: begin
        if (rd_en) begin
          iss_d = iss_q + OneLen;
        end
        dv_d = rd_en || (dv_q && !consume);
        if (consume) begin
          out_d.out_char   = rdata;
          out_d.char_valid = 1'b1;
          out_d.last       = (cons_q == (rlen_q - OneLen));
          out_vld_d        = 1'b1;
          cons_d           = cons_q + OneLen;
          if (cons_q == (rlen_q - OneLen)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      flags_q   <= '0;
      cnt_q     <= '0;
      tlen_q    <= '0;
      lim_q     <= OutLimitRst;
      out_vld_q <= 1'b0;
      rlen_q    <= '0;
      iss_q     <= '0;
      cons_q    <= '0;
      dv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      flags_q   <= flags_d;
      cnt_q     <= cnt_d;
      tlen_q    <= tlen_d;
      lim_q     <= lim_d;
      out_vld_q <= out_vld_d;
      rlen_q    <= rlen_d;
      iss_q     <= iss_d;
      cons_q    <= cons_d;
      dv_q      <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* sim/subtitle_tag_stripper_tb.sv */
// Self-checking testbench for subtitle_tag_stripper: a directed table of strings,
// then random styled strings under several output limits, checked against a predictor.
// Depends on sts_pkg and the subtitle_tag_stripper RTL.
module subtitle_tag_stripper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int unsigned TagDepth = TagDepthDef;
  localparam int MaxResults = 64;
  localparam int NumRows = 25;
  localparam int PhaseBytes = 16;

  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  subtitle_tag_stripper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  logic        p_in_tag;
  logic        p_drawing;
  logic        p_escape;
  logic        p_digits;
  logic [15:0] p_count;
  logic [15:0] p_limit;
  logic [7:0]  p_tag_buf [TagDepth];
  logic [6:0]  p_tag_len;

  out_t plain_text_q [$];
  out_t head;
  int   failures = 0;
  int   results_checked = 0;
  int   bytes_sent = 0;
  int   strings_sent = 0;
  int   limit_settings = 0;
  logic sender_calm = 1'b0;
  logic receiver_calm = 1'b0;

  function automatic void clear_string_state();
    p_in_tag = 1'b0;
    p_drawing = 1'b0;
    p_escape = 1'b0;
    p_digits = 1'b0;
    p_count = '0;
    p_tag_len = '0;
  endfunction

  function automatic void emit_char(input logic [7:0] ch, ref out_t res[$]);
    if (p_count >= p_limit || res.size() >= MaxResults) return;
    res.push_back('{out_char: ch, char_valid: 1'b1, last: 1'b0});
    p_count = p_count + 16'd1;
  endfunction

  function automatic void predict_plain_text(input in_t b, ref out_t res[$]);
    logic [7:0] c;
    logic       handled;
    c = b.in_char;
    handled = 1'b0;
    if (p_in_tag && p_tag_len < TagDepth) begin
      p_tag_buf[p_tag_len] = c;
      p_tag_len = p_tag_len + 7'd1;
    end
    if (p_in_tag) begin
      if (p_digits && c >= ChZero && c <= ChNine) begin
        if (c != ChZero) p_drawing = 1'b1;
      end else begin
        p_digits = 1'b0;
        if (p_escape && c == ChP) begin
          p_escape = 1'b0;
          p_drawing = 1'b0;
          p_digits = 1'b1;
        end else begin
          p_escape = 1'b0;
          if (c == ChClose) p_in_tag = 1'b0;
          else if (c == ChBslash) p_escape = 1'b1;
        end
      end
    end else begin
      if (p_escape) begin
        p_escape = 1'b0;
        if (c == ChUpN || c == ChLoN) begin
          emit_char(ChNewline, res);
          handled = 1'b1;
        end else if (c == ChH) begin
          emit_char(ChSpace, res);
          handled = 1'b1;
        end else if (!p_drawing) begin
          emit_char(ChBslash, res);
        end
      end
      if (!handled) begin
        if (c == ChBslash) begin
          p_escape = 1'b1;
        end else if (c == ChOpen) begin
          p_in_tag = 1'b1;
          p_tag_buf[0] = ChOpen;
          p_tag_len = 7'd1;
        end else if (!p_drawing) begin
          emit_char(c, res);
        end
      end
    end
    if (b.end_of_text) begin
      if (p_escape && !p_in_tag && !p_drawing) emit_char(ChBslash, res);
      if (p_in_tag) begin
        for (int i = 0; i < p_tag_len; i++) emit_char(p_tag_buf[i], res);
      end
      if (res.size() == 0) res.push_back('{out_char: ChNone, char_valid: 1'b0, last: 1'b0});
      res[res.size() - 1].last = 1'b1;
      clear_string_state();
    end
  endfunction

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic void build_string(ref logic [7:0] s[$]);
    int pieces;
    int parts;
    s.delete();
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s.push_back(rand_char());
        4: begin
          s.push_back(ChBslash);
          case ($urandom_range(0, 3))
            0: s.push_back(ChUpN);
            1: s.push_back(ChLoN);
            2: s.push_back(ChH);
            default: s.push_back(rand_char());
          endcase
        end
        5, 6: begin
          s.push_back(ChOpen);
          parts = $urandom_range(0, 4);
          repeat (parts) begin
            case ($urandom_range(0, 2))
              0: begin
                s.push_back(ChBslash);
                s.push_back(ChP);
                repeat ($urandom_range(0, 2)) begin
                  s.push_back($urandom_range(0, 1) ? ChZero
                                                   : 8'(ChZero + $urandom_range(1, 9)));
                end
              end
              1: begin
                s.push_back(ChBslash);
                s.push_back(rand_char());
              end
              default: s.push_back(rand_char());
            endcase
          end
          if ($urandom_range(0, 7) != 0) s.push_back(ChClose);
        end
        7: s.push_back(ChBslash);
        8: s.push_back($urandom_range(0, 1) ? ChClose : ChOpen);
        default: s.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void build_long_tag(ref logic [7:0] s[$]);
    logic [7:0] c;
    s.delete();
    s.push_back(ChOpen);
    while (s.size() < TagDepth + 8) begin
      c = 8'($urandom_range(0, 255));
      if (c != ChClose) s.push_back(c);
    end
  endfunction

  task automatic send_byte(input in_t b, input logic typed, input out_t want);
    int   gap;
    out_t res [$];
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_plain_text(b, res);
    if (typed) plain_text_q.push_back(want);
    else foreach (res[k]) plain_text_q.push_back(res[k]);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    in_t b;
    sender_calm = ($urandom_range(0, 2) == 0);
    foreach (s[i]) begin
      b.in_char = s[i];
      b.end_of_text = (i == s.size() - 1);
      send_byte(b, 1'b0, '0);
    end
    strings_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (plain_text_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_out_limit(input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    p_limit = v;
    limit_settings++;
  endtask

  initial begin : out_side
    int stall;
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (plain_text_q.size() == 0) begin
        $error("unexpected result: out_char %h char_valid %b last %b",
               out_data_o.out_char, out_data_o.char_valid, out_data_o.last);
        failures++;
      end else begin
        head = plain_text_q.pop_front();
        results_checked++;
        if (out_data_o.out_char !== head.out_char) begin
          $error("out_char: expected %h, got %h", head.out_char, out_data_o.out_char);
          failures++;
        end
        if (out_data_o.char_valid !== head.char_valid) begin
          $error("char_valid: expected %b, got %b", head.char_valid, out_data_o.char_valid);
          failures++;
        end
        if (out_data_o.last !== head.last) begin
          $error("last: expected %b, got %b", head.last, out_data_o.last);
          failures++;
        end
      end
    end
  end

  initial begin
    row_t        directed_rows [NumRows];
    logic [15:0] limits [6];
    logic [7:0]  str [$];
    int          phase_bytes;

    directed_rows = '{
      '{'{8'h41, 1'b1}, 1'b1, '{8'h41, 1'b1, 1'b1}},
      '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{'{ChNone, 1'b1}, 1'b1, '{ChNone, 1'b1, 1'b1}},
      '{'{ChBslash, 1'b1}, 1'b1, '{ChBslash, 1'b1, 1'b1}},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{ChUpN, 1'b0}, 1'b0, '0},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{ChH, 1'b0}, 1'b0, '0},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{ChLoN, 1'b0}, 1'b0, '0},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{8'h78, 1'b1}, 1'b0, '0},
      '{'{ChOpen, 1'b0}, 1'b0, '0},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{ChP, 1'b0}, 1'b0, '0},
      '{'{8'h31, 1'b0}, 1'b0, '0},
      '{'{ChClose, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b0}, 1'b0, '0},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{ChH, 1'b1}, 1'b0, '0},
      '{'{ChOpen, 1'b0}, 1'b0, '0},
      '{'{ChBslash, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b1}, 1'b0, '0},
      '{'{ChOpen, 1'b0}, 1'b0, '0},
      '{'{ChClose, 1'b1}, 1'b1, '{ChNone, 1'b0, 1'b1}}
    };
    limits = '{16'd0, 16'd1, 16'd4, 16'hFFFF, 16'($urandom_range(2, 40)), 16'd499};

    clear_string_state();
    p_limit = OutLimitRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      sender_calm = directed_rows[r].stim.end_of_text;
      send_byte(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
      if (directed_rows[r].stim.end_of_text) strings_sent++;
    end
    drain_results();

    foreach (limits[p]) begin
      set_out_limit(limits[p]);
      phase_bytes = 0;
      if (limits[p] == 16'hFFFF) begin
        build_long_tag(str);
        send_string(str);
      end
      while (phase_bytes < PhaseBytes) begin
        build_string(str);
        send_string(str);
        phase_bytes += str.size();
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes in %0d strings under %0d output limits.",
             bytes_sent, strings_sent, limit_settings);
    $display("Checked %0d plain-text results, %0d mismatches.", results_checked, failures);
    if (failures == 0) begin
      $display("subtitle_tag_stripper_tb passed");
    end else begin
      $display("subtitle_tag_stripper_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still expected.", plain_text_q.size());
    $display("subtitle_tag_stripper_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/sts_pkg.sv
hdl/sts_tag_ram.sv
hdl/sts_decode.sv
hdl/subtitle_tag_stripper.sv
sim/subtitle_tag_stripper_tb.sv
